FILE: rtl/bcs_pkg.sv
// boot check sequencer: shared types, codes and sizes
// used by every module of the block; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package bcs_pkg;

    localparam int CHECKS     = 8;
    localparam int CNT_W      = 4;
    localparam int TIME_W     = 32;
    localparam int PACK_W     = 16;
    localparam int PACK_N     = (CHECKS < PACK_W / 2) ? CHECKS : PACK_W / 2;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CNT_W-1:0]  CHECKS_CNT     = CNT_W'(CHECKS);
    localparam logic [TIME_W-1:0] DEADLINE_RESET = TIME_W'(30000);

    // register index, taken from paddr[2]
    localparam logic REG_DEADLINE = 1'b0;

    typedef enum logic [1:0] {
        KIND_BEGIN  = 2'd0,
        KIND_SUBMIT = 2'd1,
        KIND_TICK   = 2'd2,
        KIND_QUERY  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        LIFE_INACTIVE = 3'd0,
        LIFE_CHECKING = 3'd1,
        LIFE_VALID    = 3'd2,
        LIFE_ROLLBACK = 3'd3,
        LIFE_ERROR    = 3'd4
    } life_t;

    typedef enum logic [2:0] {
        FAIL_NONE         = 3'd0,
        FAIL_TIMEOUT      = 3'd1,
        FAIL_CHECK        = 3'd2,
        FAIL_ROLLBACK_API = 3'd3,
        FAIL_MARK_API     = 3'd4
    } fail_t;

    typedef enum logic [1:0] {
        RS_PENDING = 2'd0,
        RS_PASSED  = 2'd1,
        RS_FAILED  = 2'd2
    } rs_t;

    typedef enum logic [1:0] {
        CALL_NONE     = 2'd0,
        CALL_QUERY    = 2'd1,
        CALL_MARK     = 2'd2,
        CALL_ROLLBACK = 2'd3
    } call_t;

    typedef struct packed {
        kind_t              kind;
        logic [TIME_W-1:0]  now_ms;
        logic [CNT_W-1:0]   check_index;
        logic               passed;
        logic               platform_ok;
    } bcs_in_t;

    typedef struct packed {
        logic               return_flag;
        life_t              state_code;
        fail_t              failure_code;
        logic [CNT_W-1:0]   blame_index;
        logic [CNT_W-1:0]   completed;
        logic [PACK_W-1:0]  results_packed;
        call_t              platform_call;
    } bcs_out_t;

    // next_check doubles as the done count: both move together
    typedef struct packed {
        life_t                  life;
        rs_t [CHECKS-1:0]       results;
        logic [CNT_W-1:0]       next_check;
        logic [TIME_W-1:0]      start_time;
        fail_t                  reason;
        logic [CNT_W-1:0]       blamed;
    } bcs_state_t;

endpackage

`default_nettype wire

FILE: rtl/boot_check_sequencer_core.sv
// boot check sequencer top level: state registers, output register and skid stage
// depends on bcs_pkg, bcs_cfg_regs and bcs_step
//
// usage:
//   in channel (in_valid/in_stall/in_data) carries begin, submit, tick and query
//   items; out channel (out_valid/out_stall/out_data) returns one snapshot per item.
//   the deadline register sits at apb byte address 0; write it only while idle.
// throughput: one item per cycle unless in_stall is high; each item is one
//   subtract/compare on the elapsed time plus small updates, all resolved in
//   the cycle of the transfer; its result is registered in the output or skid stage.
// stall: a result waiting under out_stall stays in the output register while
//   one more item is taken into the skid stage; in_stall rises only while the
//   skid stage is full, so in_stall never depends combinationally on out_stall.
// reset: rst_n low clears the lifecycle to inactive, all checks to pending,
//   the done count and start time to zero, no failure, no blamed check, the
//   deadline to 30000 ms, and drops any result not yet transferred.
`timescale 1ns / 1ps
`default_nettype none

module boot_check_sequencer_core (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire bcs_pkg::bcs_in_t                in_data,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output bcs_pkg::bcs_out_t                    out_data,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [bcs_pkg::CFG_ADDR_W-1:0]  paddr,
    input  wire logic [bcs_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic      [bcs_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                                 pready
);
    import bcs_pkg::*;

    logic [TIME_W-1:0] deadline_ms;
    bcs_state_t        state_reg;
    bcs_state_t        state_next;
    bcs_out_t          result;
    bcs_out_t          out_reg;
    bcs_out_t          skid_reg;
    logic              out_valid_reg;
    logic              skid_valid_reg;
    logic              in_fire;
    logic              out_fire;

    bcs_cfg_regs u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .deadline_ms (deadline_ms)
    );

    bcs_step u_step (
        .cur         (state_reg),
        .item        (in_data),
        .deadline_ms (deadline_ms),
        .nxt         (state_next),
        .result      (result)
    );

    assign in_stall  = skid_valid_reg;
    assign in_fire   = in_valid && !skid_valid_reg;
    assign out_fire  = out_valid_reg && !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.life       <= LIFE_INACTIVE;
            state_reg.results    <= {CHECKS{RS_PENDING}};
            state_reg.next_check <= '0;
            state_reg.start_time <= '0;
            state_reg.reason     <= FAIL_NONE;
            state_reg.blamed     <= CHECKS_CNT;
        end
        else if (in_fire)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_fire)
                skid_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            // park the new result if the one in the output register stays
            if (out_valid_reg && !out_fire)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (out_fire)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_fire)
                out_reg <= skid_reg;
        end
        else if (in_fire)
        begin
            if (out_valid_reg && !out_fire)
                skid_reg <= result;
            else
                out_reg <= result;
        end
    end

`ifndef SYNTH
    // skid stage only fills behind a waiting result
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage holds a result while output register is empty");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.next_check <= CHECKS_CNT)
        else $error("completed count beyond check count");

    a_valid_all_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.life == LIFE_VALID) |-> (state_reg.next_check == CHECKS_CNT))
        else $error("image marked valid before all checks passed");

    a_begin_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (in_data.kind == KIND_BEGIN)) |=>
            ((state_reg.next_check == '0) && (state_reg.blamed == CHECKS_CNT)))
        else $error("begin transfer did not clear progress");
`endif

endmodule

`default_nettype wire

FILE: rtl/bcs_cfg_regs.sv
// boot check sequencer: apb register file holding the deadline
// depends on bcs_pkg
`timescale 1ns / 1ps
`default_nettype none

module bcs_cfg_regs (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [bcs_pkg::CFG_ADDR_W-1:0]  paddr,
    input  wire logic [bcs_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic      [bcs_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                                 pready,
    output logic      [bcs_pkg::TIME_W-1:0]      deadline_ms
);
    import bcs_pkg::*;

    logic [TIME_W-1:0] deadline_reg;
    logic              wr_en;
    logic              reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[CFG_ADDR_W-1];
    assign wr_en   = psel && penable && pwrite && pready && (reg_sel == REG_DEADLINE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deadline_reg <= DEADLINE_RESET;
        end
        else if (wr_en)
        begin
            deadline_reg <= pwdata[TIME_W-1:0];
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_DEADLINE: prdata = CFG_DATA_W'(deadline_reg);
            default:      prdata = '0;
        endcase
    end

    assign deadline_ms = deadline_reg;

endmodule

`default_nettype wire

FILE: rtl/bcs_step.sv
// boot check sequencer: next-state and result logic for one item
// depends on bcs_pkg
`timescale 1ns / 1ps
`default_nettype none

module bcs_step (
    input  wire bcs_pkg::bcs_state_t         cur,
    input  wire bcs_pkg::bcs_in_t            item,
    input  wire logic [bcs_pkg::TIME_W-1:0]  deadline_ms,
    output bcs_pkg::bcs_state_t              nxt,
    output bcs_pkg::bcs_out_t                result
);
    import bcs_pkg::*;

    rs_t               sub_rs;
    rs_t               tick_rs;
    logic [TIME_W-1:0] elapsed;
    logic              timeout;
    logic              checking;
    logic              sub_ok;
    logic              do_rb;
    logic              do_adv;
    fail_t             rb_reason;
    logic [CNT_W-1:0]  adv_count;
    logic              adv_last;
    logic              flag;
    call_t             call;

    // tick and submit decisions
    always_comb
    begin
        sub_rs  = RS_PENDING;
        tick_rs = RS_PENDING;
        for (int i = 0; i < CHECKS; i++)
        begin
            if (item.check_index == CNT_W'(i))
                sub_rs = cur.results[i];
            if (cur.next_check == CNT_W'(i))
                tick_rs = cur.results[i];
        end

        checking  = (cur.life == LIFE_CHECKING);
        elapsed   = item.now_ms - cur.start_time;
        timeout   = (elapsed >= deadline_ms);
        sub_ok    = (item.check_index < CHECKS_CNT) && checking && (sub_rs == RS_PENDING);
        adv_count = cur.next_check + CNT_W'(1);
        adv_last  = (adv_count == CHECKS_CNT);

        do_rb     = 1'b0;
        do_adv    = 1'b0;
        rb_reason = FAIL_TIMEOUT;
        if (checking)
        begin
            if (timeout)
            begin
                do_rb = 1'b1;
            end
            else if (cur.next_check < CHECKS_CNT)
            begin
                case (tick_rs)
                    RS_PENDING: ;
                    RS_FAILED:
                    begin
                        do_rb     = 1'b1;
                        rb_reason = FAIL_CHECK;
                    end
                    default: do_adv = 1'b1;
                endcase
            end
        end
    end

    // next state
    always_comb
    begin
        nxt = cur;
        unique case (item.kind)
            KIND_BEGIN:
            begin
                for (int i = 0; i < CHECKS; i++)
                    nxt.results[i] = RS_PENDING;
                nxt.next_check = '0;
                nxt.reason     = FAIL_NONE;
                nxt.blamed     = CHECKS_CNT;
                nxt.start_time = item.now_ms;
                nxt.life       = item.platform_ok ? LIFE_CHECKING : LIFE_INACTIVE;
            end
            KIND_SUBMIT:
            begin
                for (int i = 0; i < CHECKS; i++)
                begin
                    if (sub_ok && (item.check_index == CNT_W'(i)))
                        nxt.results[i] = item.passed ? RS_PASSED : RS_FAILED;
                end
            end
            KIND_TICK:
            begin
                if (do_rb)
                begin
                    // a timeout or a failed check blames the current check, or none once all are done
                    nxt.blamed = cur.next_check;
                    if (item.platform_ok)
                    begin
                        nxt.life   = LIFE_ROLLBACK;
                        nxt.reason = rb_reason;
                    end
                    else
                    begin
                        nxt.life   = LIFE_ERROR;
                        nxt.reason = FAIL_ROLLBACK_API;
                    end
                end
                else if (do_adv)
                begin
                    nxt.next_check = adv_count;
                    if (adv_last)
                    begin
                        if (item.platform_ok)
                        begin
                            nxt.life   = LIFE_VALID;
                            nxt.reason = FAIL_NONE;
                        end
                        else
                        begin
                            nxt.life   = LIFE_ERROR;
                            nxt.reason = FAIL_MARK_API;
                        end
                    end
                end
            end
            KIND_QUERY: ;
            default: ;
        endcase
    end

    // result flag and platform call
    always_comb
    begin
        flag = 1'b0;
        call = CALL_NONE;
        unique case (item.kind)
            KIND_BEGIN:
            begin
                flag = item.platform_ok;
                call = CALL_QUERY;
            end
            KIND_SUBMIT: flag = sub_ok;
            KIND_TICK:
            begin
                if (do_rb)
                    call = CALL_ROLLBACK;
                else if (do_adv && adv_last)
                    call = CALL_MARK;
            end
            KIND_QUERY: ;
            default: ;
        endcase
    end

    // snapshot after the item
    always_comb
    begin
        result.return_flag    = flag;
        result.state_code     = nxt.life;
        result.failure_code   = nxt.reason;
        result.blame_index    = nxt.blamed;
        result.completed      = nxt.next_check;
        result.results_packed = '0;
        for (int i = 0; i < PACK_N; i++)
            result.results_packed[2*i +: 2] = nxt.results[i];
        result.platform_call  = call;
    end

endmodule

`default_nettype wire

FILE: tb/sv/bcs_tb_pkg.sv
// boot check sequencer testbench: snapshot scoreboard with its own copy of the sequencer state
// depends on bcs_pkg for the item, snapshot and code types
`timescale 1ns / 1ps

package bcs_tb_pkg;

    import bcs_pkg::*;

    class snapshot_scoreboard;

        int errors;
        bcs_out_t expected_snapshots[$];

        logic [TIME_W-1:0] m_deadline;
        life_t             m_life;
        rs_t               m_results[CHECKS];
        logic [CNT_W-1:0]  m_next;
        logic [TIME_W-1:0] m_start;
        fail_t             m_reason;
        logic [CNT_W-1:0]  m_blamed;

        function new();
            errors     = 0;
            m_deadline = DEADLINE_RESET;
            m_life     = LIFE_INACTIVE;
            foreach (m_results[i])
                m_results[i] = RS_PENDING;
            m_next     = '0;
            m_start    = '0;
            m_reason   = FAIL_NONE;
            m_blamed   = CHECKS_CNT;
        endfunction

        function void set_deadline(logic [TIME_W-1:0] value);
            m_deadline = value;
        endfunction

        function int pending();
            return expected_snapshots.size();
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 40)
                $display("mismatch: %s", msg);
        endtask

        function call_t take_rollback(fail_t why, logic [CNT_W-1:0] who, logic ok);
            m_reason = ok ? why : FAIL_ROLLBACK_API;
            m_blamed = who;
            m_life   = ok ? LIFE_ROLLBACK : LIFE_ERROR;
            return CALL_ROLLBACK;
        endfunction

        function call_t apply_tick(bcs_in_t item);
            logic [TIME_W-1:0] elapsed;
            elapsed = item.now_ms - m_start;
            if (m_life != LIFE_CHECKING)
                return CALL_NONE;
            // wrapping elapsed time, so a zero deadline always expires
            if (elapsed >= m_deadline)
                return take_rollback(FAIL_TIMEOUT, (m_next < CHECKS_CNT) ? m_next : CHECKS_CNT,
                                     item.platform_ok);
            if (m_next >= CHECKS_CNT)
                return CALL_NONE;
            if (m_results[m_next] == RS_PENDING)
                return CALL_NONE;
            if (m_results[m_next] == RS_FAILED)
                return take_rollback(FAIL_CHECK, m_next, item.platform_ok);
            m_next++;
            if (m_next != CHECKS_CNT)
                return CALL_NONE;
            m_life   = item.platform_ok ? LIFE_VALID : LIFE_ERROR;
            m_reason = item.platform_ok ? FAIL_NONE : FAIL_MARK_API;
            return CALL_MARK;
        endfunction

        // work out the snapshot that one accepted item produces
        function void note_item(bcs_in_t item);
            bcs_out_t snap;
            snap = '0;
            snap.platform_call = CALL_NONE;
            case (item.kind)
                KIND_BEGIN:
                begin
                    foreach (m_results[i])
                        m_results[i] = RS_PENDING;
                    m_next   = '0;
                    m_reason = FAIL_NONE;
                    m_blamed = CHECKS_CNT;
                    m_start  = item.now_ms;
                    m_life   = item.platform_ok ? LIFE_CHECKING : LIFE_INACTIVE;
                    snap.return_flag   = item.platform_ok;
                    snap.platform_call = CALL_QUERY;
                end
                KIND_SUBMIT:
                begin
                    if (item.check_index < CHECKS_CNT && m_life == LIFE_CHECKING &&
                        m_results[item.check_index] == RS_PENDING)
                    begin
                        m_results[item.check_index] = item.passed ? RS_PASSED : RS_FAILED;
                        snap.return_flag = 1'b1;
                    end
                end
                KIND_TICK:
                    snap.platform_call = apply_tick(item);
                default: ;
            endcase
            snap.state_code   = m_life;
            snap.failure_code = m_reason;
            snap.blame_index  = m_blamed;
            snap.completed    = m_next;
            for (int i = 0; i < PACK_N; i++)
                snap.results_packed[2*i +: 2] = m_results[i];
            expected_snapshots.push_back(snap);
        endfunction

        task check_snapshot(bcs_out_t got);
            bcs_out_t want;
            if (expected_snapshots.size() == 0)
            begin
                report($sformatf("snapshot %h with nothing expected", got));
                return;
            end
            want = expected_snapshots.pop_front();
            if (got.return_flag !== want.return_flag)
                report($sformatf("return_flag %0d, expected %0d",
                                 got.return_flag, want.return_flag));
            if (got.state_code !== want.state_code)
                report($sformatf("state_code %0d, expected %0d",
                                 got.state_code, want.state_code));
            if (got.failure_code !== want.failure_code)
                report($sformatf("failure_code %0d, expected %0d",
                                 got.failure_code, want.failure_code));
            if (got.blame_index !== want.blame_index)
                report($sformatf("blame_index %0d, expected %0d",
                                 got.blame_index, want.blame_index));
            if (got.completed !== want.completed)
                report($sformatf("completed %0d, expected %0d",
                                 got.completed, want.completed));
            if (got.results_packed !== want.results_packed)
                report($sformatf("results_packed %h, expected %h",
                                 got.results_packed, want.results_packed));
            if (got.platform_call !== want.platform_call)
                report($sformatf("platform_call %0d, expected %0d",
                                 got.platform_call, want.platform_call));
        endtask

    endclass

endpackage

FILE: tb/sv/tb.sv
// boot check sequencer testbench top: clock, reset, item and apb drivers, output monitor
// depends on bcs_pkg, bcs_tb_pkg and boot_check_sequencer_core
`timescale 1ns / 1ps

module tb;

    import bcs_pkg::*;
    import bcs_tb_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int PHASE_ITEMS = 200;

    typedef enum {
        STALL_NONE,
        STALL_LIGHT,
        STALL_PERIODIC,
        STALL_HEAVY
    } stall_mode_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    bcs_in_t               in_data   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    bcs_out_t              out_data;
    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr     = '0;
    logic [CFG_DATA_W-1:0] pwdata    = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    snapshot_scoreboard sb = new();

    int                items_sent   = 0;
    int                burst_left   = 1;
    int                quiet_cycles = 0;
    logic [TIME_W-1:0] deadline_now = DEADLINE_RESET;

    stall_mode_t stall_mode = STALL_NONE;
    int          mode_left  = 100;
    int          stall_tick = 0;

    boot_check_sequencer_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #2 clk = ~clk;

    // receiver stall pattern, changing its character whenever mode_left runs out
    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode = stall_mode_t'($urandom_range(0, 3));
            mode_left  = $urandom_range(64, 256);
        end
        else
            mode_left--;
        stall_tick++;
        case (stall_mode)
            STALL_NONE:     out_stall <= 1'b0;
            STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
            STALL_PERIODIC: out_stall <= ((stall_tick % 5) < 2);
            default:        out_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_item(in_data);
            if (out_valid && !out_stall)
                sb.check_snapshot(out_data);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
                $display("** boot_check_sequencer_core: FAILED **");
                $finish;
            end
        end
    end

    function automatic bcs_in_t make_item(kind_t kind, logic [TIME_W-1:0] now_ms,
                                          logic [CNT_W-1:0] idx, logic passed, logic ok);
        bcs_in_t item;
        item.kind        = kind;
        item.now_ms      = now_ms;
        item.check_index = idx;
        item.passed      = passed;
        item.platform_ok = ok;
        return item;
    endfunction

    task automatic idle_for(int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // one transfer, then a random gap at the end of each burst
    task automatic push_item(bcs_in_t item);
        int gap;
        in_data  <= item;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        items_sent++;
        burst_left--;
        if (burst_left <= 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
                idle_for(gap);
            burst_left = $urandom_range(1, 40);
        end
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic apb_transfer(logic is_write, logic [CFG_DATA_W-1:0] wdata,
                                output logic [CFG_DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= {REG_DEADLINE, 2'b00};
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rdata   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_deadline(logic [TIME_W-1:0] value);
        logic [CFG_DATA_W-1:0] readback;
        wait_for_results();
        apb_transfer(1'b1, value, readback);
        sb.set_deadline(value);
        deadline_now = value;
        apb_transfer(1'b0, '0, readback);
        if (readback !== value)
            sb.report($sformatf("deadline reads %h, wrote %h", readback, value));
    endtask

    // one begin followed by submits, ticks and queries around the deadline
    task automatic run_session();
        logic [TIME_W-1:0] start;
        logic [TIME_W-1:0] elapsed;
        logic [TIME_W-1:0] step_max;
        int                pick;
        int                steps;
        start    = $urandom;
        elapsed  = '0;
        step_max = deadline_now / 24 + 1;
        steps    = $urandom_range(4, 40);
        push_item(make_item(KIND_BEGIN, start, 4'($urandom_range(0, 15)), 1'($urandom),
                            ($urandom_range(0, 9) != 0)));
        repeat (steps)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                push_item(make_item(KIND_SUBMIT, $urandom,
                                    ($urandom_range(0, 9) != 0) ? 4'($urandom_range(0, 7))
                                                                : 4'($urandom_range(8, 15)),
                                    ($urandom_range(0, 7) != 0), 1'($urandom)));
            else if (pick < 85)
            begin
                case ($urandom_range(0, 9))
                    0:       elapsed = deadline_now - 32'($urandom_range(0, 1));
                    1:       elapsed = $urandom;
                    2:       ;
                    default: elapsed = elapsed + 32'($urandom_range(0, step_max));
                endcase
                push_item(make_item(KIND_TICK, start + elapsed, 4'($urandom_range(0, 15)),
                                    1'($urandom), ($urandom_range(0, 9) != 0)));
            end
            else if (pick < 92)
                push_item(make_item(KIND_QUERY, $urandom, 4'($urandom_range(0, 15)),
                                    1'($urandom), 1'($urandom)));
            else
                push_item(make_item(kind_t'($urandom_range(0, 3)), $urandom,
                                    4'($urandom_range(0, 15)), 1'($urandom), 1'($urandom)));
        end
    endtask

    initial
    begin
        logic [TIME_W-1:0] deadlines[6];
        deadlines = '{32'd1, 32'd0, 32'hFFFF_FFFF, 32'd30000, 32'd200, 32'h0};
        deadlines[5] = $urandom;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part under the reset deadline
        push_item(make_item(KIND_QUERY, '0, '0, 1'b0, 1'b0));
        push_item(make_item(KIND_TICK, '1, '0, 1'b0, 1'b1));
        push_item(make_item(KIND_SUBMIT, '0, '0, 1'b1, 1'b1));
        push_item(make_item(KIND_BEGIN, 32'h1234, '0, 1'b0, 1'b0));
        push_item(make_item(KIND_BEGIN, 32'hFFFF_FFF0, '0, 1'b0, 1'b1));
        push_item(make_item(KIND_SUBMIT, '0, 4'd15, 1'b1, 1'b1));
        push_item(make_item(KIND_SUBMIT, '0, 4'd8, 1'b0, 1'b1));
        push_item(make_item(KIND_SUBMIT, '0, 4'd0, 1'b1, 1'b0));
        push_item(make_item(KIND_SUBMIT, '0, 4'd0, 1'b0, 1'b1));
        // elapsed time wraps past zero here
        push_item(make_item(KIND_TICK, 32'd5, '0, 1'b0, 1'b0));
        push_item(make_item(KIND_TICK, 32'd6, '0, 1'b0, 1'b1));
        push_item(make_item(KIND_SUBMIT, '0, 4'd1, 1'b0, 1'b1));
        push_item(make_item(KIND_TICK, 32'd7, '0, 1'b0, 1'b0));
        push_item(make_item(KIND_BEGIN, '0, '0, 1'b0, 1'b1));
        for (int i = 0; i < CHECKS; i++)
            push_item(make_item(KIND_SUBMIT, '0, CNT_W'(i), 1'b1, 1'b0));
        for (int i = 0; i < CHECKS; i++)
            push_item(make_item(KIND_TICK, TIME_W'(i + 1), '0, 1'b0, 1'b1));

        foreach (deadlines[p])
        begin
            set_deadline(deadlines[p]);
            // zero and maximum deadlines: expire on the first tick and at the very last ms
            push_item(make_item(KIND_BEGIN, 32'h8000_0000, '0, 1'b0, 1'b1));
            push_item(make_item(KIND_TICK, 32'h8000_0000 + deadlines[p], '0, 1'b0, 1'b1));
            while (items_sent < 40 + (p + 1) * PHASE_ITEMS)
            begin
                run_session();
                if ($urandom_range(0, 7) == 0)
                    wait_for_results();
            end
        end

        wait_for_results();
        repeat (4) @(posedge clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d snapshots never arrived", sb.pending()));
        if (sb.errors == 0)
            $display("** boot_check_sequencer_core: PASSED **");
        else
            $display("** boot_check_sequencer_core: FAILED **");
        $finish;
    end

endmodule
